### design/ysmp_pkg.sv
// Shared widths, status codes, register indexes and queue entry type of the Yukawa sampler.
package ysmp_pkg;

   localparam int LIMIT_W = 24;
   localparam int MU2_W   = 32;
   localparam int OPER_W  = 24;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   // Division operands: numerator up to 105 bits, divisor up to 98 bits
   localparam int NUM_W  = 105;
   localparam int DEN_W  = 98;
   // Quotient bits produced by the divider; anything above flags overflow
   localparam int QUO_W  = 66;
   localparam int RAD_W  = 64;
   localparam int ROOT_W = 32;

   localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_ERR = 2'd1;
   localparam logic [STAT_W-1:0] STAT_SAT = 2'd2;

   localparam logic MODE_SAMPLE  = 1'b0;
   localparam logic MODE_DENSITY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MU2         = 2'd2;

   localparam logic [LIMIT_W-1:0] LOWER_LIMIT_RST = 24'd0;
   localparam logic [LIMIT_W-1:0] UPPER_LIMIT_RST = 24'd65536;
   localparam logic [MU2_W-1:0]   MU2_RST         = 32'd65536;

   typedef struct packed {
      logic             mode;
      logic             zero;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } ysmp_entry_type;

endpackage

### design/yukawa_inverse_cdf_sampler_unit.sv
// Top level of the Yukawa inverse-CDF sampler and density unit.
//
//   channel   ports                                    direction
//   request   req_valid/req_ready, req_mode, req_operand    in
//   response  rsp_valid/rsp_ready, rsp_value, rsp_status    out
//   csr       csr_write_enable, csr_index, csr_write_data   in
//
// One request is taken per cycle while req_ready is high; a result passes through
// six front stages, the queue, one setup stage, 66 divider stages (one quotient bit each),
// one classification stage, 32 square root stages and the output register. Reset
// clears all valid flags and the queue, and loads the register defaults. A stalled
// response freezes the back pipeline; the front runs on until the queue fills, then
// holds req_ready low.
module yukawa_inverse_cdf_sampler_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic [ysmp_pkg::OPER_W-1:0]         req_operand,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ysmp_pkg::VALUE_W-1:0]        rsp_value,
   output logic [ysmp_pkg::STAT_W-1:0]         rsp_status,
   input  logic                                csr_write_enable,
   input  logic [ysmp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ysmp_pkg::CSR_DAT_W-1:0]      csr_write_data
);
   import ysmp_pkg::*;

   logic [LIMIT_W-1:0] lower_limit_ff;
   logic [LIMIT_W-1:0] upper_limit_ff;
   logic [MU2_W-1:0]   mu2_ff;

   logic           push_valid, push_ready, pop_valid, pop_ready;
   ysmp_entry_type push_entry, pop_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_limit_ff <= LOWER_LIMIT_RST;
         upper_limit_ff <= UPPER_LIMIT_RST;
         mu2_ff         <= MU2_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LOWER_LIMIT: lower_limit_ff <= csr_write_data[LIMIT_W-1:0];
            CSR_UPPER_LIMIT: upper_limit_ff <= csr_write_data[LIMIT_W-1:0];
            CSR_MU2:         mu2_ff         <= csr_write_data;
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   ysmp_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_operand       (req_operand),
      .lower_limit       (lower_limit_ff),
      .upper_limit       (upper_limit_ff),
      .screening_mass_sq (mu2_ff),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_entry        (push_entry)
   );

   ysmp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   ysmp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_entry         (pop_entry),
      .screening_mass_sq (mu2_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_value         (rsp_value),
      .rsp_status        (rsp_status)
   );

endmodule

### design/ysmp_front.sv
// Front pipeline: accepts requests, forms squares and products, builds divider operands.
module ysmp_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_mode,
   input  logic [ysmp_pkg::OPER_W-1:0]     req_operand,
   input  logic [ysmp_pkg::LIMIT_W-1:0]    lower_limit,
   input  logic [ysmp_pkg::LIMIT_W-1:0]    upper_limit,
   input  logic [ysmp_pkg::MU2_W-1:0]      screening_mass_sq,
   output logic                            push_valid,
   input  logic                            push_ready,
   output ysmp_pkg::ysmp_entry_type        push_entry
);
   import ysmp_pkg::*;

   logic        enable;
   logic [47:0] mu;

   // stage 1
   logic        v1_ff;
   logic        m1_ff;
   logic [15:0] u1_ff;
   logic [47:0] lo2_ff, hi2_ff, x2_ff;
   logic [55:0] xmu_ff;
   // stage 2
   logic        v2_ff, m2_ff, ge2_ff;
   logic [15:0] u2_ff;
   logic [48:0] a2_ff, b2_ff, s2_ff;
   logic [47:0] adiff2_ff;
   logic [56:0] num2_ff;
   // stage 3
   logic        v3_ff, m3_ff, ge3_ff;
   logic [63:0] tp3_ff;
   logic [48:0] a3_ff, b3_ff, s3_ff;
   logic [56:0] num3_ff;
   // stage 4
   logic        v4_ff, m4_ff;
   logic [49:0] d4_ff;
   logic [48:0] a4_ff, b4_ff, s4_ff;
   logic [56:0] num4_ff;
   // stage 5
   logic        v5_ff, m5_ff, z5_ff;
   logic [49:0] d5_ff;
   logic [56:0] num5_ff;
   logic [49:0] pll5_ff;
   logic [48:0] plh5_ff, phl5_ff;
   logic [47:0] phh5_ff;
   // stage 6
   logic           v6_ff;
   ysmp_entry_type e6_ff;

   logic [48:0]    mp, mq;
   logic [97:0]    prod;
   ysmp_entry_type e6_in;
   logic [49:0]    d4_in;

   assign mu        = {screening_mass_sq, 16'd0};
   assign enable    = !v6_ff || push_ready;
   assign req_ready = enable;
   assign push_valid = v6_ff;
   assign push_entry = e6_ff;

   always_comb begin
      if (ge3_ff) begin
         d4_in = {1'b0, b3_ff} - {2'b00, tp3_ff[63:16]};
      end else begin
         d4_in = {1'b0, b3_ff} + {2'b00, tp3_ff[63:16]};
      end
      mp = m4_ff ? s4_ff : a4_ff;
      mq = m4_ff ? s4_ff : b4_ff;
      prod = 98'(pll5_ff) + (98'(plh5_ff) << 25) + (98'(phl5_ff) << 25)
           + (98'(phh5_ff) << 50);
      e6_in.mode = m5_ff;
      e6_in.zero = z5_ff;
      if (m5_ff == MODE_DENSITY) begin
         e6_in.num = {num5_ff, 48'd0};
         e6_in.den = prod;
      end else begin
         e6_in.num = {7'd0, prod};
         e6_in.den = {48'd0, d5_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         m1_ff  <= req_mode;
         u1_ff  <= req_operand[15:0];
         lo2_ff <= lower_limit * lower_limit;
         hi2_ff <= upper_limit * upper_limit;
         x2_ff  <= req_operand * req_operand;
         xmu_ff <= req_operand * screening_mass_sq;

         m2_ff  <= m1_ff;
         u2_ff  <= u1_ff;
         ge2_ff <= hi2_ff >= lo2_ff;
         adiff2_ff <= (hi2_ff >= lo2_ff) ? hi2_ff - lo2_ff : lo2_ff - hi2_ff;
         a2_ff  <= {1'b0, lo2_ff} + {1'b0, mu};
         b2_ff  <= {1'b0, hi2_ff} + {1'b0, mu};
         s2_ff  <= {1'b0, x2_ff} + {1'b0, mu};
         num2_ff <= {xmu_ff, 1'b0};

         m3_ff  <= m2_ff;
         ge3_ff <= ge2_ff;
         tp3_ff <= adiff2_ff * u2_ff;
         a3_ff  <= a2_ff;
         b3_ff  <= b2_ff;
         s3_ff  <= s2_ff;
         num3_ff <= num2_ff;

         m4_ff  <= m3_ff;
         d4_ff  <= d4_in;
         a4_ff  <= a3_ff;
         b4_ff  <= b3_ff;
         s4_ff  <= s3_ff;
         num4_ff <= num3_ff;

         // split the 49 by 49 product into four partial products
         m5_ff   <= m4_ff;
         z5_ff   <= m4_ff ? (s4_ff == '0) : (d4_ff == '0);
         d5_ff   <= d4_ff;
         num5_ff <= num4_ff;
         pll5_ff <= mp[24:0] * mq[24:0];
         plh5_ff <= mp[24:0] * mq[48:25];
         phl5_ff <= mp[48:25] * mq[24:0];
         phh5_ff <= mp[48:25] * mq[48:25];

         e6_ff <= e6_in;
      end
   end

endmodule

### design/ysmp_queue.sv
// Short queue between the front and back pipelines.
module ysmp_queue #(
   parameter int DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  ysmp_pkg::ysmp_entry_type  push_entry,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output ysmp_pkg::ysmp_entry_type  pop_entry
);
   import ysmp_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   ysmp_entry_type slot_ff [0:DEPTH-1];
   logic [AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]  count_ff;
   logic           push, pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### design/ysmp_back.sv
// Back pipeline: bit-per-stage divider, result classification and square root stages.
module ysmp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  ysmp_pkg::ysmp_entry_type      pop_entry,
   input  logic [ysmp_pkg::MU2_W-1:0]    screening_mass_sq,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ysmp_pkg::VALUE_W-1:0]  rsp_value,
   output logic [ysmp_pkg::STAT_W-1:0]   rsp_status
);
   import ysmp_pkg::*;

   logic enable;

   // divider stages, index 0 is the setup stage
   logic              dv_vld_ff  [0:QUO_W];
   logic              dv_mode_ff [0:QUO_W];
   logic              dv_zero_ff [0:QUO_W];
   logic              dv_ovf_ff  [0:QUO_W];
   logic [DEN_W-1:0]  dv_den_ff  [0:QUO_W];
   logic [DEN_W-1:0]  dv_rem_ff  [0:QUO_W];
   logic [QUO_W-1:0]  dv_num_ff  [0:QUO_W];
   logic [QUO_W-1:0]  dv_quo_ff  [0:QUO_W];

   // square root stages, index 0 is the classification stage
   logic              sq_vld_ff  [0:ROOT_W];
   logic              sq_use_ff  [0:ROOT_W];
   logic [STAT_W-1:0] sq_st_ff   [0:ROOT_W];
   logic [VALUE_W-1:0] sq_val_ff [0:ROOT_W];
   logic [RAD_W-1:0]  sq_rad_ff  [0:ROOT_W];
   logic [ROOT_W+1:0] sq_rem_ff  [0:ROOT_W];
   logic [ROOT_W-1:0] sq_root_ff [0:ROOT_W];

   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic [STAT_W-1:0]  rsp_status_ff;

   logic [47:0]        mu;
   logic [QUO_W-1:0]   quo, rq;
   logic               p_use;
   logic [STAT_W-1:0]  p_st;
   logic [VALUE_W-1:0] p_val;

   assign enable     = !rsp_valid_ff || rsp_ready;
   assign pop_ready  = enable;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign mu = {screening_mass_sq, 16'd0};

   // setup: quotient of 2^66 or more is an overflow; the top bits seed the remainder
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (enable) begin
         dv_vld_ff[0] <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dv_mode_ff[0] <= pop_entry.mode;
         dv_zero_ff[0] <= pop_entry.zero;
         dv_ovf_ff[0]  <= DEN_W'(pop_entry.num[NUM_W-1:QUO_W]) >= pop_entry.den;
         dv_den_ff[0]  <= pop_entry.den;
         dv_rem_ff[0]  <= DEN_W'(pop_entry.num[NUM_W-1:QUO_W]);
         dv_num_ff[0]  <= pop_entry.num[QUO_W-1:0];
         dv_quo_ff[0]  <= '0;
      end
   end

   for (genvar j = 1; j <= QUO_W; j++) begin : g_div
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           take;

      assign trial = {dv_rem_ff[j-1], dv_num_ff[j-1][QUO_W-1]};
      assign diff  = trial - {1'b0, dv_den_ff[j-1]};
      assign take  = trial >= {1'b0, dv_den_ff[j-1]};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j] <= 1'b0;
         end else if (enable) begin
            dv_vld_ff[j] <= dv_vld_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            dv_mode_ff[j] <= dv_mode_ff[j-1];
            dv_zero_ff[j] <= dv_zero_ff[j-1];
            dv_ovf_ff[j]  <= dv_ovf_ff[j-1];
            dv_den_ff[j]  <= dv_den_ff[j-1];
            dv_rem_ff[j]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            dv_num_ff[j]  <= {dv_num_ff[j-1][QUO_W-2:0], 1'b0};
            dv_quo_ff[j]  <= {dv_quo_ff[j-1][QUO_W-2:0], take};
         end
      end
   end

   // classify: flag, saturate, pass the density quotient, or hand the radicand on to the root stages
   always_comb begin
      quo   = dv_quo_ff[QUO_W];
      rq    = quo - QUO_W'(mu);
      p_use = 1'b0;
      p_st  = STAT_OK;
      p_val = '0;
      if (dv_zero_ff[QUO_W]) begin
         p_st = STAT_ERR;
      end else if (dv_mode_ff[QUO_W] == MODE_DENSITY) begin
         if (dv_ovf_ff[QUO_W] || quo[QUO_W-1:VALUE_W] != '0) begin
            p_st  = STAT_SAT;
            p_val = '1;
         end else begin
            p_val = quo[VALUE_W-1:0];
         end
      end else begin
         if (!dv_ovf_ff[QUO_W] && quo < QUO_W'(mu)) begin
            p_st = STAT_ERR;
         end else if (dv_ovf_ff[QUO_W] || rq[QUO_W-1:RAD_W] != '0) begin
            p_st  = STAT_SAT;
            p_val = '1;
         end else begin
            p_use = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else if (enable) begin
         sq_vld_ff[0] <= dv_vld_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sq_use_ff[0]  <= p_use;
         sq_st_ff[0]   <= p_st;
         sq_val_ff[0]  <= p_val;
         sq_rad_ff[0]  <= rq[RAD_W-1:0];
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
      end
   end

   for (genvar k = 1; k <= ROOT_W; k++) begin : g_sqrt
      logic [ROOT_W+3:0] rem_t;
      logic [ROOT_W+3:0] try_v;
      logic [ROOT_W+3:0] diff;
      logic              take;

      assign rem_t = {sq_rem_ff[k-1], sq_rad_ff[k-1][RAD_W-1:RAD_W-2]};
      assign try_v = {2'b00, sq_root_ff[k-1], 2'b01};
      assign take  = rem_t >= try_v;
      assign diff  = rem_t - try_v;

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k] <= 1'b0;
         end else if (enable) begin
            sq_vld_ff[k] <= sq_vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            sq_use_ff[k]  <= sq_use_ff[k-1];
            sq_st_ff[k]   <= sq_st_ff[k-1];
            sq_val_ff[k]  <= sq_val_ff[k-1];
            sq_rad_ff[k]  <= {sq_rad_ff[k-1][RAD_W-3:0], 2'b00};
            sq_rem_ff[k]  <= take ? diff[ROOT_W+1:0] : rem_t[ROOT_W+1:0];
            sq_root_ff[k] <= {sq_root_ff[k-1][ROOT_W-2:0], take};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= sq_vld_ff[ROOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_value_ff  <= sq_use_ff[ROOT_W] ? sq_root_ff[ROOT_W] : sq_val_ff[ROOT_W];
         rsp_status_ff <= sq_st_ff[ROOT_W];
      end
   end

endmodule
